// File: design/fsbs_pkg.sv
`timescale 1ns / 1ps

package fsbs_pkg;

	localparam int HOLD_WIDTH_DEFAULT = 12;
	localparam int LIMIT_WIDTH        = 12;
	localparam int INTERVAL_WIDTH     = 10;
	localparam int RUNS_WIDTH         = 4;
	localparam int CFG_INDEX_WIDTH    = 3;
	localparam int CFG_DATA_WIDTH     = 12;

	localparam logic [INTERVAL_WIDTH-1:0] INTERVAL_RESET  = INTERVAL_WIDTH'(50);
	localparam logic [RUNS_WIDTH-1:0]     RUNS_RESET      = RUNS_WIDTH'(10);
	localparam logic [LIMIT_WIDTH-1:0]    BOTH_HOLD_RESET = LIMIT_WIDTH'(1000);
	localparam logic [LIMIT_WIDTH-1:0]    BOOT_HOLD_RESET = LIMIT_WIDTH'(3000);

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BLINK_INTERVAL = CFG_INDEX_WIDTH'(0);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BLINK_RUNS     = CFG_INDEX_WIDTH'(1);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOTH_HOLD      = CFG_INDEX_WIDTH'(2);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOOT_HOLD      = CFG_INDEX_WIDTH'(3);

	typedef struct packed {
		logic [INTERVAL_WIDTH-1:0] blink_interval;
		logic [RUNS_WIDTH-1:0]     blink_runs;
		logic [LIMIT_WIDTH-1:0]    both_hold_limit;
		logic [LIMIT_WIDTH-1:0]    boot_hold_limit;
	} cfg_t;

endpackage

// File: design/fsbs_cfg_regs.sv
`timescale 1ns / 1ps

module fsbs_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fsbs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [fsbs_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	output fsbs_pkg::cfg_t                       cfg
);
	import fsbs_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blink_interval  <= INTERVAL_RESET;
			cfg_q.blink_runs      <= RUNS_RESET;
			cfg_q.both_hold_limit <= BOTH_HOLD_RESET;
			cfg_q.boot_hold_limit <= BOOT_HOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BLINK_INTERVAL: cfg_q.blink_interval  <= cfg_data[INTERVAL_WIDTH-1:0];
				REG_BLINK_RUNS:     cfg_q.blink_runs      <= cfg_data[RUNS_WIDTH-1:0];
				REG_BOTH_HOLD:      cfg_q.both_hold_limit <= cfg_data[LIMIT_WIDTH-1:0];
				REG_BOOT_HOLD:      cfg_q.boot_hold_limit <= cfg_data[LIMIT_WIDTH-1:0];
				default: ; // drop writes to unused indexes
			endcase
		end
	end

endmodule

// File: design/footswitch_toggle_and_blink_sequencer.sv
`timescale 1ns / 1ps
// The result of a tick beat is presented on the cycle after it is taken.
// Throughput: one tick beat per cycle while out_stall is low; the only limit is the
// single result register, which is refilled in the same cycle it is drained.
// Reset (arst_n low, asynchronous): effect off, both LEDs on, counters and blink run
// cleared, registers back to interval 50, runs 10, both-hold 1000, boot-hold 3000.

module footswitch_toggle_and_blink_sequencer #(
	parameter int HOLD_WIDTH = fsbs_pkg::HOLD_WIDTH_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fsbs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [fsbs_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 switch_one_pressed,
	input  logic                                 switch_two_pressed,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 led_one_level,
	output logic                                 led_two_level,
	output logic                                 effect_enabled,
	output logic                                 boot_request,
	output logic                                 blinking
);
	import fsbs_pkg::*;

	localparam int CmpW = (HOLD_WIDTH > LIMIT_WIDTH) ? HOLD_WIDTH : LIMIT_WIDTH;

	cfg_t cfg;

	fsbs_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	logic                      effect_q, led_one_q, led_two_q;
	logic [1:0]                prev_q;
	logic [HOLD_WIDTH-1:0]     hold_one_q, hold_two_q;
	logic                      active_q, phase_q;
	logic [RUNS_WIDTH-1:0]     blink_cnt_q;
	logic [INTERVAL_WIDTH-1:0] ival_cnt_q;
	logic                      boot_q;
	logic                      out_valid_q;

	logic                      effect_d, led_one_d, led_two_d;
	logic [HOLD_WIDTH-1:0]     hold_one_d, hold_two_d;
	logic                      active_d, phase_d;
	logic [RUNS_WIDTH-1:0]     blink_cnt_d;
	logic [INTERVAL_WIDTH-1:0] ival_cnt_d;
	logic                      boot_d;
	logic                      press_edge, start;
	logic [CmpW-1:0]           hold_one_x, hold_two_x, both_x, boot_x;

	logic in_fire, out_fire;

	// Take a new beat whenever the result register is empty or being drained.
	assign in_stall = out_valid_q && out_stall;
	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid_q && !out_stall;

	always_comb begin
		hold_one_d = '0;
		if (switch_one_pressed && prev_q[0])
			hold_one_d = (hold_one_q == '1) ? hold_one_q : hold_one_q + 1'b1;
		hold_two_d = '0;
		if (switch_two_pressed && prev_q[1])
			hold_two_d = (hold_two_q == '1) ? hold_two_q : hold_two_q + 1'b1;

		hold_one_x = CmpW'(hold_one_d);
		hold_two_x = CmpW'(hold_two_d);
		both_x     = CmpW'(cfg.both_hold_limit);
		boot_x     = CmpW'(cfg.boot_hold_limit);

		press_edge = switch_one_pressed && !prev_q[0];
		effect_d   = effect_q ^ press_edge;
		led_one_d  = press_edge ? !effect_d : led_one_q;
		led_two_d  = led_two_q;

		boot_d = switch_one_pressed && (hold_one_x > boot_x);

		start = !active_q && switch_one_pressed && switch_two_pressed &&
			(hold_one_x > both_x) && (hold_two_x > both_x);

		active_d    = active_q || start;
		blink_cnt_d = start ? '0 : blink_cnt_q;
		phase_d     = start ? 1'b0 : phase_q;
		ival_cnt_d  = ival_cnt_q;

		if (active_d) begin
			if (start)
				ival_cnt_d = '0;
			else if (ival_cnt_q != '1)
				ival_cnt_d = ival_cnt_q + 1'b1;
			if (ival_cnt_d >= cfg.blink_interval) begin
				phase_d    = !phase_d;
				led_one_d  = !phase_d;
				led_two_d  = !phase_d;
				ival_cnt_d = '0;
				// count a blink each time the phase comes back to low
				if (!phase_d) begin
					blink_cnt_d = blink_cnt_d + 1'b1;
					if (blink_cnt_d >= cfg.blink_runs) begin
						active_d    = 1'b0;
						led_one_d   = !effect_d;
						led_two_d   = 1'b1;
						blink_cnt_d = '0;
						phase_d     = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			effect_q    <= 1'b0;
			led_one_q   <= 1'b1;
			led_two_q   <= 1'b1;
			prev_q      <= '0;
			hold_one_q  <= '0;
			hold_two_q  <= '0;
			active_q    <= 1'b0;
			phase_q     <= 1'b0;
			blink_cnt_q <= '0;
			ival_cnt_q  <= '0;
			boot_q      <= 1'b0;
		end else if (in_fire) begin
			effect_q    <= effect_d;
			led_one_q   <= led_one_d;
			led_two_q   <= led_two_d;
			prev_q      <= {switch_two_pressed, switch_one_pressed};
			hold_one_q  <= hold_one_d;
			hold_two_q  <= hold_two_d;
			active_q    <= active_d;
			phase_q     <= phase_d;
			blink_cnt_q <= blink_cnt_d;
			ival_cnt_q  <= ival_cnt_d;
			boot_q      <= boot_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	// State only moves on an accepted beat, so it doubles as the held result.
	assign out_valid      = out_valid_q;
	assign led_one_level  = led_one_q;
	assign led_two_level  = led_two_q;
	assign effect_enabled = effect_q;
	assign boot_request   = boot_q;
	assign blinking       = active_q;

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (ival_cnt_q == '0 && phase_q == 1'b0 && blink_cnt_q == '0))
		else $error("blink counters not cleared outside a run");

	a_boot_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !switch_one_pressed) |=> (!boot_request && hold_one_q == '0))
		else $error("boot request or hold count survives a release");

	a_edge_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && switch_one_pressed && !prev_q[0]) |=> (effect_q != $past(effect_q)))
		else $error("press edge did not toggle the effect");

	a_no_edge_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !(switch_one_pressed && !prev_q[0])) |=> $stable(effect_q))
		else $error("effect changed without a press edge");

	a_result_follows_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid)
		else $error("accepted beat produced no result");

endmodule

// File: verif/tb_footswitch_toggle_and_blink_sequencer.sv
`timescale 1ns / 1ps

module tb_footswitch_toggle_and_blink_sequencer;
	import fsbs_pkg::*;

	localparam int HOLD_W = HOLD_WIDTH_DEFAULT;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED_FIRST = CFG_INDEX_WIDTH'(4);

	typedef struct packed {
		logic led_one;
		logic led_two;
		logic effect;
		logic boot;
		logic blink;
	} tick_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic switch_one_pressed = 1'b0;
	logic switch_two_pressed = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic led_one_level;
	logic led_two_level;
	logic effect_enabled;
	logic boot_request;
	logic blinking;

	footswitch_toggle_and_blink_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.switch_one_pressed(switch_one_pressed),
		.switch_two_pressed(switch_two_pressed),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.led_one_level(led_one_level),
		.led_two_level(led_two_level),
		.effect_enabled(effect_enabled),
		.boot_request(boot_request),
		.blinking(blinking)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor copy of the registers and state
	logic [INTERVAL_WIDTH-1:0] cfg_interval;
	logic [RUNS_WIDTH-1:0]     cfg_runs;
	logic [LIMIT_WIDTH-1:0]    cfg_both;
	logic [LIMIT_WIDTH-1:0]    cfg_boot;
	bit effect_on, led1, led2, prev1, prev2, run_active, phase;
	logic [HOLD_W-1:0] hold1, hold2;
	logic [RUNS_WIDTH-1:0] blink_cnt;
	logic [INTERVAL_WIDTH-1:0] ivl_cnt;

	tick_result_t pending_tick_results [$];
	int send_idle_pct = 11;
	int recv_idle_pct = 76;
	int recv_hold_left = 0;
	int mismatch_count = 0;
	int beats_checked = 0;
	string field_names [5] = '{"led_one_level", "led_two_level", "effect_enabled",
		"boot_request", "blinking"};

	task automatic reset_predictor();
		cfg_interval = INTERVAL_RESET;
		cfg_runs = RUNS_RESET;
		cfg_both = BOTH_HOLD_RESET;
		cfg_boot = BOOT_HOLD_RESET;
		effect_on = 1'b0;
		led1 = 1'b1;
		led2 = 1'b1;
		prev1 = 1'b0;
		prev2 = 1'b0;
		run_active = 1'b0;
		phase = 1'b0;
		hold1 = '0;
		hold2 = '0;
		blink_cnt = '0;
		ivl_cnt = '0;
	endtask

	function automatic void store_register(logic [CFG_INDEX_WIDTH-1:0] idx,
		logic [CFG_DATA_WIDTH-1:0] data);
		case (idx)
			REG_BLINK_INTERVAL: cfg_interval = data[INTERVAL_WIDTH-1:0];
			REG_BLINK_RUNS:     cfg_runs = data[RUNS_WIDTH-1:0];
			REG_BOTH_HOLD:      cfg_both = data[LIMIT_WIDTH-1:0];
			REG_BOOT_HOLD:      cfg_boot = data[LIMIT_WIDTH-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [HOLD_W-1:0] next_hold(logic [HOLD_W-1:0] cnt, bit now, bit was);
		if (!now || !was)
			return '0;
		return (&cnt) ? cnt : cnt + 1'b1;
	endfunction

	function automatic tick_result_t step_sequencer(bit s1, bit s2);
		bit boot;
		bit started;
		started = 1'b0;
		hold1 = next_hold(hold1, s1, prev1);
		hold2 = next_hold(hold2, s2, prev2);
		if (s1 && !prev1) begin
			effect_on = !effect_on;
			led1 = !effect_on;
		end
		boot = s1 && (hold1 > cfg_boot);
		if (!run_active && s1 && s2 && hold1 > cfg_both && hold2 > cfg_both) begin
			run_active = 1'b1;
			blink_cnt = '0;
			phase = 1'b0;
			started = 1'b1;
		end
		if (run_active) begin
			if (started)
				ivl_cnt = '0;
			else if (!(&ivl_cnt))
				ivl_cnt = ivl_cnt + 1'b1;
			if (ivl_cnt >= cfg_interval) begin
				phase = !phase;
				led1 = !phase;
				led2 = !phase;
				ivl_cnt = '0;
				// a full blink is counted when the phase comes back to zero
				if (!phase) begin
					blink_cnt = blink_cnt + 1'b1;
					if (blink_cnt >= cfg_runs) begin
						run_active = 1'b0;
						led1 = !effect_on;
						led2 = 1'b1;
						blink_cnt = '0;
						ivl_cnt = '0;
						phase = 1'b0;
					end
				end
			end
		end
		prev1 = s1;
		prev2 = s2;
		return {led1, led2, effect_on, boot, run_active};
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("result %0d: %s", beats_checked, what);
	endtask

	always @(posedge clk) begin
		if (recv_hold_left > 0) begin
			out_stall <= 1'b1;
			recv_hold_left--;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		tick_result_t want;
		tick_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = {led_one_level, led_two_level, effect_enabled, boot_request, blinking};
			if (pending_tick_results.size() == 0) begin
				report_mismatch("result beat with no tick waiting");
			end else begin
				want = pending_tick_results.pop_front();
				for (int f = 0; f < 5; f++)
					if (got[4-f] !== want[4-f])
						report_mismatch($sformatf("%s expected %b got %b",
							field_names[f], want[4-f], got[4-f]));
			end
			beats_checked++;
		end
	end

	task automatic send_tick(input bit s1, input bit s2);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		switch_one_pressed <= s1;
		switch_two_pressed <= s2;
		do @(posedge clk); while (in_stall);
		pending_tick_results.push_back(step_sequencer(s1, s2));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_tick_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// write all four registers, then one unmapped index that must be ignored
	task automatic program_regs(input logic [CFG_DATA_WIDTH-1:0] interval_data,
		input logic [CFG_DATA_WIDTH-1:0] runs_data, input logic [CFG_DATA_WIDTH-1:0] both_data,
		input logic [CFG_DATA_WIDTH-1:0] boot_data);
		logic [CFG_INDEX_WIDTH-1:0] idx [5];
		logic [CFG_DATA_WIDTH-1:0] val [5];
		idx = '{REG_BLINK_INTERVAL, REG_BLINK_RUNS, REG_BOTH_HOLD, REG_BOOT_HOLD,
			REG_UNMAPPED_FIRST + CFG_INDEX_WIDTH'($urandom_range(0, 3))};
		val = '{interval_data, runs_data, both_data, boot_data, CFG_DATA_WIDTH'($urandom)};
		for (int k = 0; k < 5; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= val[k];
			do @(posedge clk); while (!cfg_ready);
			store_register(idx[k], val[k]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_and_toggle();
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
	endtask

	// zero interval toggles on the start tick, zero runs ends at the first blink
	task automatic test_zero_interval_and_runs();
		drain_results();
		program_regs(12'hC00, 12'hFF0, 12'd1, 12'd2);
		repeat (6) send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b0);
	endtask

	// press switch one again while a run is going
	task automatic test_edge_during_run();
		drain_results();
		program_regs(12'd2, 12'd2, 12'd0, 12'd4094);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b1);
		repeat (8) send_tick(1'b0, 1'b0);
	endtask

	task automatic test_longest_run_count();
		drain_results();
		program_regs(12'hC01, 12'h00F, 12'd0, 12'd0);
		repeat (70) send_tick(1'b1, 1'b1);
		repeat (3) send_tick(1'b0, 1'b0);
	endtask

	// hold both long enough to saturate, then wait out a run at the widest interval
	task automatic test_hold_saturation();
		drain_results();
		program_regs(12'h3FF, 12'd1, 12'd4094, 12'd4094);
		repeat (4100) send_tick(1'b1, 1'b1);
		repeat (2060) send_tick(1'b0, 1'b0);
	endtask

	task automatic test_backpressure();
		drain_results();
		send_idle_pct = 0;
		recv_hold_left = 300;
		repeat (40) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		// pause until the whole backlog has come out
		drain_results();
		repeat (10) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct,
		input int n_ticks);
		int sent;
		int kind;
		int len;
		int span;
		bit b;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		for (int setting = 0; setting < 2; setting++) begin
			drain_results();
			program_regs({2'($urandom), 10'($urandom_range(0, 6))},
				{8'($urandom), 4'($urandom_range(0, 4))},
				12'($urandom_range(0, 12)), 12'($urandom_range(0, 25)));
			while (sent < (setting + 1) * n_ticks / 2) begin
				kind = $urandom_range(0, 9);
				if (kind < 4) begin
					span = cfg_both + 2 * (cfg_interval + 1) * (cfg_runs + 1) + 4;
					len = $urandom_range(1, span < 80 ? span : 80);
					repeat (len) send_tick(1'b1, 1'b1);
				end else if (kind < 6) begin
					span = cfg_boot + 4;
					len = $urandom_range(1, span);
					b = 1'($urandom_range(0, 1));
					repeat (len) send_tick(1'b1, b);
				end else if (kind == 6) begin
					len = $urandom_range(1, 20);
					repeat (len) send_tick(1'b0, 1'b1);
				end else if (kind < 9) begin
					len = $urandom_range(1, 8);
					repeat (len) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end else begin
					len = $urandom_range(1, 4);
					repeat (len) send_tick(1'b0, 1'b0);
				end
				sent += len;
				if (kind < 7 && $urandom_range(0, 1)) begin
					send_tick(1'b0, 1'b0);
					sent++;
				end
			end
		end
	endtask

	initial begin
		reset_predictor();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_and_toggle();
		test_zero_interval_and_runs();
		test_edge_during_run();
		test_longest_run_count();
		test_hold_saturation();
		test_backpressure();
		test_random_traffic(11, 76, 450);
		test_random_traffic(76, 11, 450);
		test_random_traffic(0, 0, 450);
		drain_results();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
